// ===== design/thj_pkg.sv =====
// ----------------------------------------------------------------------------
// thj_pkg: shared definitions for the hexahedron Jacobian block
// Widths, corner sign table, sequencer step map and the control bundle.
// ----------------------------------------------------------------------------
package thj_pkg;

	localparam int VERTEX_COUNT = 8;
	localparam int VTX_W        = $clog2(VERTEX_COUNT);
	localparam int PT_W         = 16;
	localparam int COORD_W      = 32;
	localparam int FAC_W        = PT_W + 1;
	localparam int DER_W        = 33;
	localparam int PROD_W       = DER_W + COORD_W;
	localparam int FRAC_SHIFT   = 28;
	localparam int SUM_W        = 40;
	localparam int JAC_W        = 36;
	localparam int SCALE_SHIFT  = 3;
	localparam int N_TERMS      = 9;
	localparam int STEP_W       = 4;
	localparam int TIDX_W       = $clog2(N_TERMS);

	localparam logic signed [FAC_W-1:0] ONE_Q14 = 17'sd16384;

	// step map of one vertex
	localparam logic [STEP_W-1:0] STEP_TERM0 = 4'd3;  // first term multiply
	localparam logic [STEP_W-1:0] STEP_DWR0  = 4'd1;  // first derivative store
	localparam logic [STEP_W-1:0] STEP_DWR2  = 4'd3;  // last derivative store
	localparam logic [STEP_W-1:0] STEP_ACC0  = 4'd4;  // first accumulate
	localparam logic [STEP_W-1:0] STEP_LAST  = 4'd12; // last accumulate

	// corner signs, bit set = positive; bit 0 xi, bit 1 eta, bit 2 zeta
	localparam logic [2:0] CORNER_SIGN [VERTEX_COUNT] = '{
		3'b000, 3'b001, 3'b011, 3'b010, 3'b100, 3'b101, 3'b111, 3'b110
	};

	typedef logic signed [JAC_W-1:0] jac_t;

	typedef struct packed {
		logic              ready;
		logic              take;
		logic              latch_pt;
		logic [VTX_W-1:0]  corner;
		logic              mul_deriv;
		logic [TIDX_W-1:0] mul_idx;
		logic              d_wr;
		logic [1:0]        d_idx;
		logic              acc_wr;
		logic [TIDX_W-1:0] acc_idx;
		logic              acc_fresh;
		logic              load_out;
	} ctrl_t;

	// column (derivative direction) of a term index
	function automatic logic [1:0] term_col(input logic [TIDX_W-1:0] idx);
		logic [1:0] c;
		case (idx)
			4'd0, 4'd1, 4'd2: c = 2'd0;
			4'd3, 4'd4, 4'd5: c = 2'd1;
			4'd6, 4'd7, 4'd8: c = 2'd2;
			default:          c = 2'd0;
		endcase
		return c;
	endfunction

	// row (coordinate) of a term index
	function automatic logic [1:0] term_row(input logic [TIDX_W-1:0] idx);
		logic [1:0] r;
		case (idx)
			4'd0, 4'd3, 4'd6: r = 2'd0;
			4'd1, 4'd4, 4'd7: r = 2'd1;
			4'd2, 4'd5, 4'd8: r = 2'd2;
			default:          r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/thj_vertex_if.sv =====
// ----------------------------------------------------------------------------
// thj_vertex_if: vertex input channel
// Valid/ready handshake carrying the reference point and one vertex.
// ----------------------------------------------------------------------------
interface thj_vertex_if;
	logic                                valid;
	logic                                ready;
	logic signed [thj_pkg::PT_W-1:0]     xi;
	logic signed [thj_pkg::PT_W-1:0]     eta;
	logic signed [thj_pkg::PT_W-1:0]     zeta;
	logic signed [thj_pkg::COORD_W-1:0]  vert_x;
	logic signed [thj_pkg::COORD_W-1:0]  vert_y;
	logic signed [thj_pkg::COORD_W-1:0]  vert_z;

	modport source (output valid, xi, eta, zeta, vert_x, vert_y, vert_z, input ready);
	modport sink   (input valid, xi, eta, zeta, vert_x, vert_y, vert_z, output ready);
endinterface

// ===== design/thj_jacobian_if.sv =====
// ----------------------------------------------------------------------------
// thj_jacobian_if: Jacobian result channel
// Valid/ready handshake carrying the nine matrix entries, Q20.16.
// ----------------------------------------------------------------------------
interface thj_jacobian_if;
	logic          valid;
	logic          ready;
	thj_pkg::jac_t dx_dxi;
	thj_pkg::jac_t dy_dxi;
	thj_pkg::jac_t dz_dxi;
	thj_pkg::jac_t dx_deta;
	thj_pkg::jac_t dy_deta;
	thj_pkg::jac_t dz_deta;
	thj_pkg::jac_t dx_dzeta;
	thj_pkg::jac_t dy_dzeta;
	thj_pkg::jac_t dz_dzeta;

	modport source (output valid, dx_dxi, dy_dxi, dz_dxi, dx_deta, dy_deta, dz_deta,
		dx_dzeta, dy_dzeta, dz_dzeta, input ready);
	modport sink   (input valid, dx_dxi, dy_dxi, dz_dxi, dx_deta, dy_deta, dz_deta,
		dx_dzeta, dy_dzeta, dz_dzeta, output ready);
endinterface

// ===== design/trilinear_hex_jacobian.sv =====
// ----------------------------------------------------------------------------
// trilinear_hex_jacobian: Jacobian of the trilinear hexahedron map
// Takes eight vertices per element and returns the 3x3 Jacobian, Q20.16.
// ----------------------------------------------------------------------------
//  channel  dir  payload                              transaction
//  vtx      in   xi eta zeta (Q1.14), vert_x/y/z      one vertex, corner order
//  jac      out  nine entries, 36 bit Q20.16          one matrix per element
//
//  Each vertex is accepted, then runs 13 steps of the one shared 33x32
//  multiplier (three derivative products, nine coordinate terms, one step to
//  drain into the accumulator bank). After the eighth vertex an emit state
//  loads the output register once no previous matrix is waiting. vtx.ready
//  is low during the steps. Reset clears the vertex counter and handshake
//  state; the point is taken again from vertex zero.
// ----------------------------------------------------------------------------
module trilinear_hex_jacobian (
	input  logic                  clk,
	input  logic                  arst_n,
	thj_vertex_if.sink            vtx,
	thj_jacobian_if.source        jac
);

	thj_pkg::ctrl_t ctrl;
	thj_pkg::jac_t  sums  [thj_pkg::N_TERMS];
	thj_pkg::jac_t  jac_q [thj_pkg::N_TERMS];
	logic           out_valid_q;
	logic           out_stall;

	assign out_stall = out_valid_q && !jac.ready;

	thj_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vtx.valid),
		.out_stall (out_stall),
		.ctrl      (ctrl)
	);

	thj_mac u_mac (
		.clk    (clk),
		.ctrl   (ctrl),
		.xi     (vtx.xi),
		.eta    (vtx.eta),
		.zeta   (vtx.zeta),
		.vert_x (vtx.vert_x),
		.vert_y (vtx.vert_y),
		.vert_z (vtx.vert_z),
		.jac    (sums)
	);

	assign vtx.ready = ctrl.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctrl.load_out)
			out_valid_q <= 1'b1;
		else if (jac.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out)
			jac_q <= sums;
	end

	assign jac.valid    = out_valid_q;
	assign jac.dx_dxi   = jac_q[0];
	assign jac.dy_dxi   = jac_q[1];
	assign jac.dz_dxi   = jac_q[2];
	assign jac.dx_deta  = jac_q[3];
	assign jac.dy_deta  = jac_q[4];
	assign jac.dz_deta  = jac_q[5];
	assign jac.dx_dzeta = jac_q[6];
	assign jac.dy_dzeta = jac_q[7];
	assign jac.dz_dzeta = jac_q[8];

`ifndef SYNTH
	// never overwrite a matrix that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out |-> !out_stall)
		else $error("result overwritten while stalled");

	// a loaded matrix is offered on the next cycle
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out |=> jac.valid)
		else $error("loaded result not presented");

	// no new vertex while the datapath is busy with the last one
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(vtx.valid && vtx.ready) |=> !vtx.ready)
		else $error("vertex accepted during processing");

	// accumulation and derivative stores happen only while not ready
	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.acc_wr || ctrl.d_wr) |-> !vtx.ready)
		else $error("datapath write while idle");
`endif

endmodule

// ===== design/thj_seq.sv =====
// ----------------------------------------------------------------------------
// thj_seq: vertex sequencer
// Steps the shared multiplier through three derivative products and nine
// coordinate terms per vertex, tracks the corner and triggers the result.
// ----------------------------------------------------------------------------
module thj_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           out_stall,
	output thj_pkg::ctrl_t ctrl
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                  state_q;
	logic [thj_pkg::STEP_W-1:0]  step_q;
	logic [thj_pkg::VTX_W-1:0]   vcnt_q;
	logic                        run;

	assign run = (state_q == ST_RUN);

	always_comb begin
		ctrl           = '0;
		ctrl.ready     = (state_q == ST_IDLE);
		ctrl.take      = ctrl.ready && in_valid;
		ctrl.latch_pt  = ctrl.take && (vcnt_q == '0);
		ctrl.corner    = vcnt_q;
		ctrl.mul_deriv = (step_q < thj_pkg::STEP_TERM0);
		ctrl.mul_idx   = ctrl.mul_deriv ? step_q : (step_q - thj_pkg::STEP_TERM0);
		ctrl.d_wr      = run && (step_q >= thj_pkg::STEP_DWR0)
			&& (step_q <= thj_pkg::STEP_DWR2);
		ctrl.d_idx     = 2'(step_q - thj_pkg::STEP_DWR0);
		ctrl.acc_wr    = run && (step_q >= thj_pkg::STEP_ACC0);
		ctrl.acc_idx   = step_q - thj_pkg::STEP_ACC0;
		ctrl.acc_fresh = (vcnt_q == '0);
		ctrl.load_out  = (state_q == ST_EMIT) && !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			vcnt_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctrl.take) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == thj_pkg::STEP_LAST) begin
						// last vertex goes on to hand off the matrix
						state_q <= (vcnt_q == thj_pkg::VTX_W'(thj_pkg::VERTEX_COUNT - 1))
							? ST_EMIT : ST_IDLE;
						vcnt_q  <= vcnt_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (ctrl.load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/thj_mac.sv =====
// ----------------------------------------------------------------------------
// thj_mac: shared multiply-accumulate datapath
// Holds the reference point and vertex, forms the shape-function derivatives
// and accumulates the nine Jacobian sums through one multiplier.
// ----------------------------------------------------------------------------
module thj_mac (
	input  logic                               clk,
	input  thj_pkg::ctrl_t                     ctrl,
	input  logic signed [thj_pkg::PT_W-1:0]    xi,
	input  logic signed [thj_pkg::PT_W-1:0]    eta,
	input  logic signed [thj_pkg::PT_W-1:0]    zeta,
	input  logic signed [thj_pkg::COORD_W-1:0] vert_x,
	input  logic signed [thj_pkg::COORD_W-1:0] vert_y,
	input  logic signed [thj_pkg::COORD_W-1:0] vert_z,
	output thj_pkg::jac_t                      jac [thj_pkg::N_TERMS]
);

	logic signed [thj_pkg::PT_W-1:0]    pt_q  [3];
	logic signed [thj_pkg::COORD_W-1:0] v_q   [3];
	logic signed [thj_pkg::DER_W-1:0]   d_q   [3];
	logic signed [thj_pkg::SUM_W-1:0]   sum_q [thj_pkg::N_TERMS];
	logic signed [thj_pkg::FAC_W-1:0]   fac   [3];
	logic signed [thj_pkg::FAC_W-1:0]   fneg  [3];
	logic [2:0]                         sgn;
	logic signed [thj_pkg::DER_W-1:0]   mul_a;
	logic signed [thj_pkg::COORD_W-1:0] mul_b;
	logic signed [thj_pkg::PROD_W-1:0]  prod_s1;
	logic signed [thj_pkg::SUM_W-1:0]   term;
	logic signed [thj_pkg::SUM_W-1:0]   acc_base;

	assign sgn = thj_pkg::CORNER_SIGN[ctrl.corner];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fac[i]  = sgn[i] ? (thj_pkg::ONE_Q14 + thj_pkg::FAC_W'(pt_q[i]))
				: (thj_pkg::ONE_Q14 - thj_pkg::FAC_W'(pt_q[i]));
			fneg[i] = -fac[i];
		end
	end

	// operand select: derivative products first, then coordinate terms
	always_comb begin
		if (ctrl.mul_deriv) begin
			case (ctrl.mul_idx)
				4'd0: begin
					mul_a = thj_pkg::DER_W'(fac[1]);
					mul_b = thj_pkg::COORD_W'(sgn[0] ? fac[2] : fneg[2]);
				end
				4'd1: begin
					mul_a = thj_pkg::DER_W'(fac[0]);
					mul_b = thj_pkg::COORD_W'(sgn[1] ? fac[2] : fneg[2]);
				end
				default: begin
					mul_a = thj_pkg::DER_W'(fac[0]);
					mul_b = thj_pkg::COORD_W'(sgn[2] ? fac[1] : fneg[1]);
				end
			endcase
		end else begin
			mul_a = d_q[thj_pkg::term_col(ctrl.mul_idx)];
			mul_b = v_q[thj_pkg::term_row(ctrl.mul_idx)];
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		if (ctrl.latch_pt) begin
			pt_q[0] <= xi;
			pt_q[1] <= eta;
			pt_q[2] <= zeta;
		end
		if (ctrl.take) begin
			v_q[0] <= vert_x;
			v_q[1] <= vert_y;
			v_q[2] <= vert_z;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.d_wr)
			d_q[ctrl.d_idx] <= prod_s1[thj_pkg::DER_W-1:0];
	end

	// floor of the product by 2^28, sign-extended to the sum width
	assign term = {{(thj_pkg::SUM_W - thj_pkg::PROD_W + thj_pkg::FRAC_SHIFT)
		{prod_s1[thj_pkg::PROD_W-1]}}, prod_s1[thj_pkg::PROD_W-1:thj_pkg::FRAC_SHIFT]};

	// vertex zero starts every sum afresh
	assign acc_base = ctrl.acc_fresh ? '0 : sum_q[ctrl.acc_idx];

	always_ff @(posedge clk) begin
		if (ctrl.acc_wr)
			sum_q[ctrl.acc_idx] <= acc_base + term;
	end

	always_comb begin
		for (int i = 0; i < thj_pkg::N_TERMS; i++)
			jac[i] = sum_q[i][thj_pkg::JAC_W+thj_pkg::SCALE_SHIFT-1:thj_pkg::SCALE_SHIFT];
	end

endmodule
